/* sv/multi_queue_priority_head_scheduler_top_assert.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef MULTI_QUEUE_PRIORITY_HEAD_SCHEDULER_TOP_ASSERT_SVH
`define MULTI_QUEUE_PRIORITY_HEAD_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MQPHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define MQPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed: next-cycle rule");

`endif

/* sv/mqphs_pkg.sv */
`timescale 1ns / 1ps

package mqphs_pkg;

    localparam int MAX_LINES  = 16;
    localparam int LINE_DEPTH = 64;

    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int EL_W   = LINE_W + 1;
    localparam int PTR_W  = $clog2(LINE_DEPTH);
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = LINE_W + PTR_W;

    localparam int ID_W      = 16;
    localparam int KEY_W     = 16;
    localparam int LIDX_W    = 4;
    localparam int NLINES_W  = 5;
    localparam int SLOT_W    = ID_W + 2 * KEY_W;
    localparam logic [ID_W-1:0] POP_MAX = '1;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    localparam logic CFG_NUM_LINES = 1'b0;
    localparam logic CFG_TARGET_ID = 1'b1;

    typedef struct packed {
        logic [NLINES_W-1:0] num_lines;
        logic [ID_W-1:0]     target_id;
    } t_cfg;

    typedef struct packed {
        logic [ID_W-1:0]   item_id;
        logic [LIDX_W-1:0] line_index;
        logic [KEY_W-1:0]  item_days;
        logic [KEY_W-1:0]  item_urgency;
        logic              is_target;
        logic [ID_W-1:0]   served_before;
        logic              none_waiting;
        logic              line_full;
    } t_result;

endpackage

/* sv/mqphs_ram.sv */
`timescale 1ns / 1ps

module mqphs_ram #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mqphs_core.sv */
`timescale 1ns / 1ps

module mqphs_core import mqphs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  logic             i_op,
    input  logic [KEY_W-1:0] i_days,
    input  logic [KEY_W-1:0] i_urgency,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_POP,
        S_RES
    } t_state;

    t_state            r_state;
    logic [PTR_W-1:0]  r_head [MAX_LINES];
    logic [CNT_W-1:0]  r_fill [MAX_LINES];
    logic [ID_W-1:0]   r_next_id;
    logic [LINE_W-1:0] r_next_line;
    logic [ID_W-1:0]   r_pop;
    logic [LINE_W-1:0] r_scan;
    logic              r_p_vld;
    logic [LINE_W-1:0] r_p_line;
    logic              r_found;
    logic [LINE_W-1:0] r_best;
    logic [KEY_W-1:0]  r_bd;
    logic [KEY_W-1:0]  r_bu;
    logic [ID_W-1:0]   r_bid;
    t_result           r_res;

    logic [EL_W-1:0]   eff_lines;
    logic [LINE_W-1:0] enq_line;
    logic [EL_W-1:0]   enq_next;
    logic [LINE_W-1:0] rd_idx;
    logic [PTR_W-1:0]  head_rd;
    logic [CNT_W-1:0]  fill_rd;
    logic              enq_full;
    logic              req_fire;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_rdata;
    logic [ID_W-1:0]   h_id;
    logic [KEY_W-1:0]  h_days;
    logic [KEY_W-1:0]  h_urg;
    logic              better;
    logic [ID_W-1:0]   pop_inc;

    // Effective line count: zero acts as one, large values clamp.
    always_comb begin
        if (i_cfg.num_lines == '0) begin
            eff_lines = EL_W'(1);
        end else if (32'(i_cfg.num_lines) > MAX_LINES) begin
            eff_lines = EL_W'(MAX_LINES);
        end else begin
            eff_lines = EL_W'(i_cfg.num_lines);
        end
    end

    assign enq_line = ({1'b0, r_next_line} >= eff_lines) ? '0 : r_next_line;
    assign enq_next = {1'b0, enq_line} + EL_W'(1);

    always_comb begin
        case (r_state)
            S_IDLE:  rd_idx = enq_line;
            S_SCAN:  rd_idx = r_scan;
            default: rd_idx = r_best;
        endcase
    end

    assign head_rd   = r_head[rd_idx];
    assign fill_rd   = r_fill[rd_idx];
    assign enq_full  = (fill_rd >= CNT_W'(LINE_DEPTH));
    assign req_fire  = i_req_valid && (r_state == S_IDLE);
    assign mem_we    = req_fire && (i_op == OP_ENQUEUE) && !enq_full;
    assign mem_waddr = {enq_line, head_rd + fill_rd[PTR_W-1:0]};

    mqphs_ram #(
        .DATA_W(SLOT_W),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata({r_next_id, i_days, i_urgency}),
        .i_re   (r_state == S_SCAN),
        .i_raddr({r_scan, head_rd}),
        .o_rdata(mem_rdata)
    );

    assign {h_id, h_days, h_urg} = mem_rdata;
    assign better  = !r_found || (h_days > r_bd) || ((h_days == r_bd) && (h_urg > r_bu));
    assign pop_inc = (r_pop == POP_MAX) ? r_pop : r_pop + ID_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_id   <= '0;
            r_next_line <= '0;
            r_pop       <= '0;
            r_found     <= 1'b0;
            r_p_vld     <= 1'b0;
            for (int k = 0; k < MAX_LINES; k++) begin
                r_head[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        if (i_op == OP_ENQUEUE) begin
                            r_res.item_id       <= r_next_id;
                            r_res.line_index    <= LIDX_W'(enq_line);
                            r_res.item_days     <= i_days;
                            r_res.item_urgency  <= i_urgency;
                            r_res.is_target     <= 1'b0;
                            r_res.served_before <= r_pop;
                            r_res.none_waiting  <= 1'b0;
                            r_res.line_full     <= enq_full;
                            if (!enq_full) begin
                                r_fill[enq_line] <= fill_rd + CNT_W'(1);
                                r_next_id        <= r_next_id + ID_W'(1);
                                r_next_line      <= (enq_next >= eff_lines) ? '0
                                                    : enq_next[LINE_W-1:0];
                            end
                            r_state <= S_RES;
                        end else begin
                            r_scan  <= '0;
                            r_found <= 1'b0;
                            r_p_vld <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Read of line r_scan is in flight; compare the previous line's head.
                    if (r_p_vld && better) begin
                        r_found <= 1'b1;
                        r_best  <= r_p_line;
                        r_bd    <= h_days;
                        r_bu    <= h_urg;
                        r_bid   <= h_id;
                    end
                    r_p_vld  <= (fill_rd != '0);
                    r_p_line <= r_scan;
                    r_scan   <= r_scan + LINE_W'(1);
                    if (32'(r_scan) == MAX_LINES - 1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_p_vld && better) begin
                        r_found <= 1'b1;
                        r_best  <= r_p_line;
                        r_bd    <= h_days;
                        r_bu    <= h_urg;
                        r_bid   <= h_id;
                    end
                    r_p_vld <= 1'b0;
                    r_state <= S_POP;
                end
                S_POP: begin
                    r_res.line_full <= 1'b0;
                    if (!r_found) begin
                        r_res.item_id       <= '0;
                        r_res.line_index    <= '0;
                        r_res.item_days     <= '0;
                        r_res.item_urgency  <= '0;
                        r_res.is_target     <= 1'b0;
                        r_res.served_before <= r_pop;
                        r_res.none_waiting  <= 1'b1;
                    end else begin
                        r_res.item_id      <= r_bid;
                        r_res.line_index   <= LIDX_W'(r_best);
                        r_res.item_days    <= r_bd;
                        r_res.item_urgency <= r_bu;
                        r_res.none_waiting <= 1'b0;
                        if (r_bid == i_cfg.target_id) begin
                            r_res.is_target     <= 1'b1;
                            r_res.served_before <= r_pop;
                        end else begin
                            r_res.is_target     <= 1'b0;
                            r_res.served_before <= pop_inc;
                            r_pop               <= pop_inc;
                            r_head[r_best]      <= head_rd + PTR_W'(1);
                            r_fill[r_best]      <= fill_rd - CNT_W'(1);
                        end
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RES);
    assign o_res       = r_res;

endmodule

/* sv/multi_queue_priority_head_scheduler_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        to block   i_in_valid / o_in_stall      i_op, i_days, i_urgency
// out       from block o_out_valid / i_out_stall    o_item_id .. o_line_full
// cfg       to block   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An enqueue result is held in the core and then in the output register; a serve result
// first scans all MAX_LINES lines, as the FIFO heads are read one per cycle through the
// single read port of the line store. The input stalls until the core passes it on.
// Reset is synchronous and active low; it empties every line and clears the
// id, line and pop counters. The line store itself is never cleared.
// The output register lets the next request enter while a result waits on a stall.

module multi_queue_priority_head_scheduler_top import mqphs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [KEY_W-1:0]  i_days,
    input  logic [KEY_W-1:0]  i_urgency,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ID_W-1:0]   o_item_id,
    output logic [LIDX_W-1:0] o_line_index,
    output logic [KEY_W-1:0]  o_item_days,
    output logic [KEY_W-1:0]  o_item_urgency,
    output logic              o_is_target,
    output logic [ID_W-1:0]   o_served_before,
    output logic              o_none_waiting,
    output logic              o_line_full,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [ID_W-1:0]   i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    // Configuration writes are always taken; the registers feed the core directly.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_lines <= NLINES_W'(1);
            r_cfg.target_id <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_LINES: r_cfg.num_lines <= i_cfg_data[NLINES_W-1:0];
                CFG_TARGET_ID: r_cfg.target_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mqphs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req_valid(i_in_valid),
        .o_req_stall(o_in_stall),
        .i_op       (i_op),
        .i_days     (i_days),
        .i_urgency  (i_urgency),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    // The output register can be reloaded in the same cycle its result leaves.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_item_id       = r_out.item_id;
    assign o_line_index    = r_out.line_index;
    assign o_item_days     = r_out.item_days;
    assign o_item_urgency  = r_out.item_urgency;
    assign o_is_target     = r_out.is_target;
    assign o_served_before = r_out.served_before;
    assign o_none_waiting  = r_out.none_waiting;
    assign o_line_full     = r_out.line_full;

`include "multi_queue_priority_head_scheduler_top_assert.svh"

    // An accepted request takes the core out of idle and so stalls the input.
    `MQPHS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A kept target is a real head, neither an empty serve nor a refused enqueue.
    `MQPHS_ASSERT_NOW(a_target_flags, i_clk, i_rst_n, o_out_valid && o_is_target, !o_none_waiting && !o_line_full)
    // An empty serve reports zero id and line.
    `MQPHS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_none_waiting, o_item_id == '0 && o_line_index == '0 && !o_is_target)

endmodule
